### sv/ppc_iiu_pkg.sv
// ----------------------------------------------------------------------------
// PowerPC immediate integer unit package
// Shared command codes, decoded operation type, item records and helpers.
// ----------------------------------------------------------------------------
package ppc_iiu_pkg;

	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = 5;
	localparam int DATA_W    = 32;
	localparam int QDEPTH    = 2;

	// Command codes of the input item.
	localparam logic [3:0] CMD_TWI     = 4'd0;
	localparam logic [3:0] CMD_MULLI   = 4'd1;
	localparam logic [3:0] CMD_SUBFIC  = 4'd2;
	localparam logic [3:0] CMD_CMPLI   = 4'd3;
	localparam logic [3:0] CMD_CMPI    = 4'd4;
	localparam logic [3:0] CMD_ADDIC   = 4'd5;
	localparam logic [3:0] CMD_ADDIC_R = 4'd6;
	localparam logic [3:0] CMD_ADDI    = 4'd7;
	localparam logic [3:0] CMD_ADDIS   = 4'd8;
	localparam logic [3:0] CMD_ORI     = 4'd9;
	localparam logic [3:0] CMD_ORIS    = 4'd10;
	localparam logic [3:0] CMD_XORI    = 4'd11;
	localparam logic [3:0] CMD_XORIS   = 4'd12;
	localparam logic [3:0] CMD_ANDI_R  = 4'd13;
	localparam logic [3:0] CMD_ANDIS_R = 4'd14;

	// Condition field bits.
	localparam logic [3:0] CR_LT = 4'h8;
	localparam logic [3:0] CR_GT = 4'h4;
	localparam logic [3:0] CR_EQ = 4'h2;

	// Bit positions in the trap mask.
	localparam int TO_LT  = 4;
	localparam int TO_GT  = 3;
	localparam int TO_EQ  = 2;
	localparam int TO_LTU = 1;
	localparam int TO_GTU = 0;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TRAP,
		OP_MUL,
		OP_SUBF,
		OP_CMPU,
		OP_CMPS,
		OP_ADDC,
		OP_ADD,
		OP_OR,
		OP_XOR,
		OP_AND
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [REG_IDX_W-1:0]  src_idx;
		logic                  zero_base;
		logic [REG_IDX_W-1:0]  dest_idx;
		logic [DATA_W-1:0]     operand;
		logic                  rec;
		logic [4:0]            to_mask;
		logic [2:0]            cr_idx;
	} dec_t;

	typedef struct packed {
		logic                  reg_write;
		logic [REG_IDX_W-1:0]  reg_index;
		logic [DATA_W-1:0]     reg_value;
		logic                  cr_write;
		logic [2:0]            cr_index;
		logic [3:0]            cr_value;
		logic                  carry_out;
		logic                  trap_taken;
	} res_t;

	function automatic logic [3:0] cmp_code(input logic lt, input logic gt, input logic so);
		logic [3:0] c;
		c = lt ? CR_LT : (gt ? CR_GT : CR_EQ);
		return c | {3'b000, so};
	endfunction

endpackage

### sv/ppc_iiu_front.sv
// ----------------------------------------------------------------------------
// PowerPC immediate integer unit front end
// Accepts items, decodes the command and queues the decoded item.
// ----------------------------------------------------------------------------
module ppc_iiu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [3:0]           command,
	input  logic [4:0]           field_first,
	input  logic [4:0]           field_second,
	input  logic [15:0]          immediate,
	input  logic                 push,
	output logic                 full,
	output logic                 dq_valid,
	output ppc_iiu_pkg::dec_t    dq_item,
	input  logic                 dq_pop
);

	ppc_iiu_pkg::dec_t dec;
	logic [31:0]       simm;
	logic [31:0]       zimm;
	logic [31:0]       himm;
	logic              push_ok;
	logic              pop_ok;

	ppc_iiu_pkg::dec_t mem_q [ppc_iiu_pkg::QDEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	assign simm = {{16{immediate[15]}}, immediate};
	assign zimm = {16'h0000, immediate};
	assign himm = {immediate, 16'h0000};

	always_comb begin
		dec           = '0;
		dec.op        = ppc_iiu_pkg::OP_NONE;
		dec.to_mask   = field_first;
		dec.cr_idx    = field_first[4:2];
		dec.src_idx   = field_second;
		dec.dest_idx  = field_first;
		dec.operand   = simm;
		case (command)
			ppc_iiu_pkg::CMD_TWI:    dec.op = ppc_iiu_pkg::OP_TRAP;
			ppc_iiu_pkg::CMD_MULLI:  dec.op = ppc_iiu_pkg::OP_MUL;
			ppc_iiu_pkg::CMD_SUBFIC: dec.op = ppc_iiu_pkg::OP_SUBF;
			ppc_iiu_pkg::CMD_CMPLI: begin
				dec.op      = ppc_iiu_pkg::OP_CMPU;
				dec.operand = zimm;
			end
			ppc_iiu_pkg::CMD_CMPI:   dec.op = ppc_iiu_pkg::OP_CMPS;
			ppc_iiu_pkg::CMD_ADDIC:  dec.op = ppc_iiu_pkg::OP_ADDC;
			ppc_iiu_pkg::CMD_ADDIC_R: begin
				dec.op  = ppc_iiu_pkg::OP_ADDC;
				dec.rec = 1'b1;
			end
			ppc_iiu_pkg::CMD_ADDI: begin
				dec.op        = ppc_iiu_pkg::OP_ADD;
				dec.zero_base = 1'b1;
			end
			ppc_iiu_pkg::CMD_ADDIS: begin
				dec.op        = ppc_iiu_pkg::OP_ADD;
				dec.zero_base = 1'b1;
				dec.operand   = himm;
			end
			ppc_iiu_pkg::CMD_ORI, ppc_iiu_pkg::CMD_ORIS: begin
				dec.op       = ppc_iiu_pkg::OP_OR;
				dec.src_idx  = field_first;
				dec.dest_idx = field_second;
				dec.operand  = (command == ppc_iiu_pkg::CMD_ORI) ? zimm : himm;
			end
			ppc_iiu_pkg::CMD_XORI, ppc_iiu_pkg::CMD_XORIS: begin
				dec.op       = ppc_iiu_pkg::OP_XOR;
				dec.src_idx  = field_first;
				dec.dest_idx = field_second;
				dec.operand  = (command == ppc_iiu_pkg::CMD_XORI) ? zimm : himm;
			end
			ppc_iiu_pkg::CMD_ANDI_R, ppc_iiu_pkg::CMD_ANDIS_R: begin
				dec.op       = ppc_iiu_pkg::OP_AND;
				dec.rec      = 1'b1;
				dec.src_idx  = field_first;
				dec.dest_idx = field_second;
				dec.operand  = (command == ppc_iiu_pkg::CMD_ANDI_R) ? zimm : himm;
			end
			default: dec.op = ppc_iiu_pkg::OP_NONE;
		endcase
	end

	// Two-entry decoded item queue.
	assign full     = (cnt_q == 2'(ppc_iiu_pkg::QDEPTH));
	assign dq_valid = (cnt_q != 2'd0);
	assign dq_item  = mem_q[rd_ptr_q];
	assign push_ok  = push & ~full;
	assign pop_ok   = dq_pop & dq_valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/ppc_iiu_back.sv
// ----------------------------------------------------------------------------
// PowerPC immediate integer unit back end
// Executes decoded items against the register file and queues the results.
// ----------------------------------------------------------------------------
module ppc_iiu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 dq_valid,
	input  ppc_iiu_pkg::dec_t    dq_item,
	output logic                 dq_pop,
	output logic                 res_empty,
	output ppc_iiu_pkg::res_t    res_item,
	input  logic                 res_pop
);

	logic [ppc_iiu_pkg::DATA_W-1:0] rf_q [ppc_iiu_pkg::REG_COUNT];
	logic                           carry_q;
	logic                           so_q;

	ppc_iiu_pkg::res_t rq_q [ppc_iiu_pkg::QDEPTH];
	logic              rq_wr_ptr_q;
	logic              rq_rd_ptr_q;
	logic [1:0]        rq_cnt_q;
	logic              rq_full;
	logic              rq_pop_ok;

	logic                           exec;
	logic [ppc_iiu_pkg::DATA_W-1:0] a;
	logic [ppc_iiu_pkg::DATA_W-1:0] b;
	logic [ppc_iiu_pkg::DATA_W:0]   sum;
	logic                           slt_ab;
	logic                           slt_ba;
	ppc_iiu_pkg::res_t              res;
	logic                           carry_d;

	assign rq_full   = (rq_cnt_q == 2'(ppc_iiu_pkg::QDEPTH));
	assign res_empty = (rq_cnt_q == 2'd0);
	assign res_item  = rq_q[rq_rd_ptr_q];
	assign rq_pop_ok = res_pop & ~res_empty;

	assign exec   = dq_valid & ~rq_full;
	assign dq_pop = exec;

	// Register zero reads as zero only for the add-immediate forms.
	assign a = (dq_item.zero_base && (dq_item.src_idx == '0)) ? '0 : rf_q[dq_item.src_idx];
	assign b = dq_item.operand;

	assign sum    = {1'b0, a} + {1'b0, b};
	assign slt_ab = $signed(a) < $signed(b);
	assign slt_ba = $signed(b) < $signed(a);

	always_comb begin
		res           = '0;
		carry_d       = carry_q;
		case (dq_item.op)
			ppc_iiu_pkg::OP_TRAP: begin
				res.trap_taken = (dq_item.to_mask[ppc_iiu_pkg::TO_LT]  & slt_ab) |
				                 (dq_item.to_mask[ppc_iiu_pkg::TO_GT]  & slt_ba) |
				                 (dq_item.to_mask[ppc_iiu_pkg::TO_EQ]  & (a == b)) |
				                 (dq_item.to_mask[ppc_iiu_pkg::TO_LTU] & (a < b)) |
				                 (dq_item.to_mask[ppc_iiu_pkg::TO_GTU] & (a > b));
			end
			ppc_iiu_pkg::OP_MUL: begin
				res.reg_write = 1'b1;
				res.reg_value = a * b;
			end
			ppc_iiu_pkg::OP_SUBF: begin
				res.reg_write = 1'b1;
				res.reg_value = b - a;
				carry_d       = (b >= a);
			end
			ppc_iiu_pkg::OP_CMPU: begin
				res.cr_write = 1'b1;
				res.cr_index = dq_item.cr_idx;
				res.cr_value = ppc_iiu_pkg::cmp_code(a < b, a > b, so_q);
			end
			ppc_iiu_pkg::OP_CMPS: begin
				res.cr_write = 1'b1;
				res.cr_index = dq_item.cr_idx;
				res.cr_value = ppc_iiu_pkg::cmp_code(slt_ab, slt_ba, so_q);
			end
			ppc_iiu_pkg::OP_ADDC: begin
				res.reg_write = 1'b1;
				res.reg_value = sum[ppc_iiu_pkg::DATA_W-1:0];
				carry_d       = sum[ppc_iiu_pkg::DATA_W];
			end
			ppc_iiu_pkg::OP_ADD: begin
				res.reg_write = 1'b1;
				res.reg_value = sum[ppc_iiu_pkg::DATA_W-1:0];
			end
			ppc_iiu_pkg::OP_OR: begin
				res.reg_write = 1'b1;
				res.reg_value = a | b;
			end
			ppc_iiu_pkg::OP_XOR: begin
				res.reg_write = 1'b1;
				res.reg_value = a ^ b;
			end
			ppc_iiu_pkg::OP_AND: begin
				res.reg_write = 1'b1;
				res.reg_value = a & b;
			end
			default: res.reg_write = 1'b0;
		endcase
		if (res.reg_write) begin
			res.reg_index = dq_item.dest_idx;
		end
		// Record forms compare the result with zero into field zero.
		if (dq_item.rec) begin
			res.cr_write = 1'b1;
			res.cr_index = 3'd0;
			res.cr_value = ppc_iiu_pkg::cmp_code(res.reg_value[ppc_iiu_pkg::DATA_W-1],
				(res.reg_value != '0) && !res.reg_value[ppc_iiu_pkg::DATA_W-1], so_q);
		end
		res.carry_out = carry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppc_iiu_pkg::REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
			carry_q <= 1'b0;
			so_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				so_q <= cfg_wdata;
			end
			if (exec) begin
				carry_q <= carry_d;
				if (res.reg_write) begin
					rf_q[res.reg_index] <= res.reg_value;
				end
			end
		end
	end

	// Two-entry result queue.
	always_ff @(posedge clk) begin
		if (exec) begin
			rq_q[rq_wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_ptr_q <= 1'b0;
			rq_rd_ptr_q <= 1'b0;
			rq_cnt_q    <= 2'd0;
		end else begin
			if (exec) begin
				rq_wr_ptr_q <= ~rq_wr_ptr_q;
			end
			if (rq_pop_ok) begin
				rq_rd_ptr_q <= ~rq_rd_ptr_q;
			end
			case ({exec, rq_pop_ok})
				2'b10:   rq_cnt_q <= rq_cnt_q + 2'd1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 2'd1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= 2'(ppc_iiu_pkg::QDEPTH))
		else $error("result queue count out of range");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> !res_empty)
		else $error("executed item left no result");

	a_carry_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(carry_q) |-> $past(exec) &&
			($past(dq_item.op) == ppc_iiu_pkg::OP_SUBF ||
			 $past(dq_item.op) == ppc_iiu_pkg::OP_ADDC))
		else $error("carry changed without a carrying instruction");

	a_no_stall_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(dq_valid && !rq_full) |-> dq_pop)
		else $error("back end stalled with room for a result");

endmodule

### sv/ppc_iiu_core.sv
// ----------------------------------------------------------------------------
// PowerPC immediate integer unit core
// Top level: decoding front end, queue, and executing back end.
// ----------------------------------------------------------------------------
// The block executes one PowerPC D-form integer instruction per input item.
// Input items enter through a queue interface: an item is taken at a rising
// edge where push is high and full is low. Results leave through a second
// queue interface: the oldest result is on the result ports while empty is
// low and is taken at a rising edge where pop is high.
//
// An accepted item is written, decoded, into the two-entry decoded queue; the
// back end executes it from there and writes its result into the result
// queue, where it becomes visible. The back end reads and writes the register
// file in the same cycle, so one item per cycle, set by the single execute
// stage, is kept with no dependency stalls while the result queue has room.
// When the receiver stops popping, the two-entry result queue fills, the back
// end stops draining the decoded queue, and full rises once that fills too.
// Reset clears the registers, carry, summary overflow and both queues.
// The summary overflow register is written with cfg_we and cfg_wdata.
// ----------------------------------------------------------------------------
module ppc_immediate_integer_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  command,
	input  logic [4:0]  field_first,
	input  logic [4:0]  field_second,
	input  logic [15:0] immediate,
	output logic        empty,
	input  logic        pop,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        cr_write,
	output logic [2:0]  cr_index,
	output logic [3:0]  cr_value,
	output logic        carry_out,
	output logic        trap_taken
);

	logic              dq_valid;
	logic              dq_pop;
	ppc_iiu_pkg::dec_t dq_item;
	ppc_iiu_pkg::res_t res_item;

	// The front end decodes each item as it is accepted.
	ppc_iiu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.field_first  (field_first),
		.field_second (field_second),
		.immediate    (immediate),
		.push         (push),
		.full         (full),
		.dq_valid     (dq_valid),
		.dq_item      (dq_item),
		.dq_pop       (dq_pop)
	);

	// The back end owns the architectural state and the result queue.
	ppc_iiu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.dq_valid  (dq_valid),
		.dq_item   (dq_item),
		.dq_pop    (dq_pop),
		.res_empty (empty),
		.res_item  (res_item),
		.res_pop   (pop)
	);

	assign reg_write  = res_item.reg_write;
	assign reg_index  = res_item.reg_index;
	assign reg_value  = res_item.reg_value;
	assign cr_write   = res_item.cr_write;
	assign cr_index   = res_item.cr_index;
	assign cr_value   = res_item.cr_value;
	assign carry_out  = res_item.carry_out;
	assign trap_taken = res_item.trap_taken;

endmodule
